// File: hdl/onr_pkg.sv
// Shared types and constants of the Oren-Nayar reflectance pipeline.
`default_nettype none
package onr_pkg;

	localparam int unsigned FRAC = 14;
	localparam int unsigned ONE = 16384;
	localparam int unsigned TH = (9999 * ONE) / 10000;

	localparam logic [22:0] K33 = 23'd5536481;
	localparam logic [22:0] K09 = 23'd1509949;
	localparam logic [22:0] K45 = 23'd7549747;

	localparam logic [7:0] REG_COEFF_A = 8'd0;
	localparam logic [7:0] REG_COEFF_B = 8'd1;

	localparam int unsigned NSTAGE = 60;

	// Step windows of the bit-serial units, one step per stage.
	localparam int unsigned SQ_FIRST = 6;
	localparam int unsigned SQ_LAST = 36;
	localparam int unsigned SN_LAST = 20;
	localparam int unsigned DA_LAST = 20;
	localparam int unsigned DB_LAST = 28;
	localparam int unsigned TD_FIRST = 21;
	localparam int unsigned TD_LAST = 51;
	localparam int unsigned MC_FIRST = 39;
	localparam int unsigned MC_LAST = 54;

	typedef struct packed {
		logic [2:0][15:0] lv;
		logic [2:0][15:0] vv;
		logic [2:0][15:0] nv;
		logic             use_s;
		logic [15:0]      sigma;
		logic [2:0][31:0] pl;
		logic [2:0][31:0] pv;
		logic [31:0]      sig2;
		logic [54:0]      numb;
		logic [32:0]      dena;
		logic [32:0]      denb;
		logic [33:0]      ra;
		logic [14:0]      qa;
		logic [33:0]      rb;
		logic [22:0]      qb;
		logic [15:0]      ci;
		logic [15:0]      co;
		logic [15:0]      cb;
		logic [2:0][31:0] m1;
		logic [2:0][31:0] m2;
		logic [28:0]      ca2;
		logic [28:0]      cb2;
		logic             gate;
		logic [2:0][17:0] p1;
		logic [2:0][17:0] p2;
		logic             cb_neg;
		logic [14:0]      den;
		logic [2:0][35:0] pp;
		logic [2:0][35:0] q1;
		logic [2:0][35:0] q2;
		logic [37:0]      d;
		logic             mc_ok;
		logic [63:0]      sq1_v;
		logic [63:0]      sq1_r;
		logic [63:0]      sq2_v;
		logic [63:0]      sq2_r;
		logic [31:0]      sn_v;
		logic [31:0]      sn_r;
		logic [31:0]      sb_v;
		logic [31:0]      sb_r;
		logic [16:0]      td_rem;
		logic [30:0]      tq;
		logic [61:0]      prod;
		logic [63:0]      mrem;
		logic             sat;
		logic [15:0]      mq;
		logic [16:0]      maxcos;
		logic [31:0]      tanv;
		logic [16:0]      a;
		logic [16:0]      b;
		logic [17:0]      t1;
		logic [17:0]      t2;
		logic [33:0]      t3;
		logic [16:0]      refl;
	} item_t;

	// Work of pipeline stage k; k is a constant at each call site.
	function automatic item_t stage_step(input item_t x, input int unsigned k,
			input logic [16:0] cfg_a, input logic [16:0] cfg_b);
		item_t y;
		logic signed [33:0] dl;
		logic signed [33:0] dv;
		logic signed [19:0] shl;
		logic signed [19:0] shv;
		logic signed [15:0] ca;
		logic signed [15:0] cbs;
		logic signed [31:0] tmp1;
		logic signed [31:0] tmp2;
		logic signed [37:0] n1s;
		logic signed [37:0] n2s;
		logic signed [37:0] ds;
		logic [63:0] bit64;
		logic [31:0] bit32;
		logic [30:0] dvd;
		logic [16:0] trem;
		logic [33:0] qrem;
		logic [63:0] mr;
		logic [16:0] sinq;
		logic [34:0] t2w;
		logic signed [51:0] t3w;
		logic signed [34:0] rs;
		y = x;
		dl = '0; dv = '0; shl = '0; shv = '0; ca = '0; cbs = '0;
		tmp1 = '0; tmp2 = '0; n1s = '0; n2s = '0; ds = '0;
		bit64 = '0; bit32 = '0; dvd = '0; trem = '0; qrem = '0; mr = '0;
		sinq = '0; t2w = '0; t3w = '0; rs = '0;
		if (k == 0) begin
			for (int j = 0; j < 3; j++) begin
				y.pl[j] = $signed(x.nv[j]) * $signed(x.lv[j]);
				y.pv[j] = $signed(x.nv[j]) * $signed(x.vv[j]);
			end
			y.sig2 = 32'(x.sigma) * 32'(x.sigma);
		end
		if (k == 1) begin
			dl = $signed(x.pl[0]) + $signed(x.pl[1]) + $signed(x.pl[2]);
			dv = $signed(x.pv[0]) + $signed(x.pv[1]) + $signed(x.pv[2]);
			shl = 20'(dl >>> FRAC);
			shv = 20'(dv >>> FRAC);
			if (shl > $signed(20'(ONE))) shl = 20'(ONE);
			if (shl < -$signed(20'(ONE))) shl = -$signed(20'(ONE));
			if (shv > $signed(20'(ONE))) shv = 20'(ONE);
			if (shv < -$signed(20'(ONE))) shv = -$signed(20'(ONE));
			y.ci = shl[15:0];
			y.co = shv[15:0];
			y.numb = 55'(x.sig2) * 55'(K45);
			y.dena = 33'(x.sig2) + 33'(K33);
			y.denb = 33'(x.sig2) + 33'(K09);
			y.ra = 34'(x.sig2);
			y.qa = '0;
		end
		if (k == 2) begin
			for (int j = 0; j < 3; j++) begin
				y.m1[j] = $signed(x.nv[j]) * $signed(x.ci);
				y.m2[j] = $signed(x.nv[j]) * $signed(x.co);
			end
			if ($signed(x.co) >= $signed(x.ci)) begin
				ca = $signed(x.ci);
				cbs = $signed(x.co);
			end else begin
				ca = $signed(x.co);
				cbs = $signed(x.ci);
			end
			// square at full width; a unit cosine squared needs 29 bits
			tmp1 = ca * ca;
			tmp2 = cbs * cbs;
			y.ca2 = tmp1[28:0];
			y.cb2 = tmp2[28:0];
			y.cb = cbs;
			y.gate = ($signed(x.ci) < $signed(16'(TH))) && ($signed(x.co) < $signed(16'(TH)));
			y.rb = 34'(x.numb[54:23]);
			y.qb = '0;
		end
		if (k == 3) begin
			for (int j = 0; j < 3; j++) begin
				tmp1 = ($signed(x.lv[j]) * $signed(32'(ONE))) - $signed(x.m1[j]);
				tmp2 = ($signed(x.vv[j]) * $signed(32'(ONE))) - $signed(x.m2[j]);
				y.p1[j] = 18'(tmp1 >>> FRAC);
				y.p2[j] = 18'(tmp2 >>> FRAC);
			end
			y.sn_v = 32'(ONE * ONE) - 32'(x.ca2);
			y.sn_r = '0;
			y.sb_v = 32'(ONE * ONE) - 32'(x.cb2);
			y.sb_r = '0;
			y.cb_neg = x.cb[15];
			if (x.cb == '0) y.den = 15'd1;
			else if (x.cb[15]) y.den = 15'(-$signed(x.cb));
			else y.den = x.cb[14:0];
			y.td_rem = '0;
			y.tq = '0;
		end
		if (k == 4) begin
			for (int j = 0; j < 3; j++) begin
				y.pp[j] = $signed(x.p1[j]) * $signed(x.p2[j]);
				y.q1[j] = $signed(x.p1[j]) * $signed(x.p1[j]);
				y.q2[j] = $signed(x.p2[j]) * $signed(x.p2[j]);
			end
		end
		if (k == 5) begin
			ds = $signed(x.pp[0]) + $signed(x.pp[1]) + $signed(x.pp[2]);
			n1s = $signed(x.q1[0]) + $signed(x.q1[1]) + $signed(x.q1[2]);
			n2s = $signed(x.q2[0]) + $signed(x.q2[1]) + $signed(x.q2[2]);
			y.d = ds;
			y.mc_ok = x.gate && (ds > 0) && (n1s > 0) && (n2s > 0);
			y.sq1_v = {n1s[35:0], 28'd0};
			y.sq2_v = {n2s[35:0], 28'd0};
			y.sq1_r = '0;
			y.sq2_r = '0;
		end
		if (k >= SQ_FIRST && k <= SQ_LAST) begin
			bit64 = 64'd1 << (2 * (SQ_LAST - k));
			if (x.sq1_v >= x.sq1_r + bit64) begin
				y.sq1_v = x.sq1_v - (x.sq1_r + bit64);
				y.sq1_r = (x.sq1_r >> 1) + bit64;
			end else begin
				y.sq1_r = x.sq1_r >> 1;
			end
			if (x.sq2_v >= x.sq2_r + bit64) begin
				y.sq2_v = x.sq2_v - (x.sq2_r + bit64);
				y.sq2_r = (x.sq2_r >> 1) + bit64;
			end else begin
				y.sq2_r = x.sq2_r >> 1;
			end
		end
		if (k >= SQ_FIRST && k <= SN_LAST) begin
			bit32 = 32'd1 << (2 * (SN_LAST - k));
			if (x.sn_v >= x.sn_r + bit32) begin
				y.sn_v = x.sn_v - (x.sn_r + bit32);
				y.sn_r = (x.sn_r >> 1) + bit32;
			end else begin
				y.sn_r = x.sn_r >> 1;
			end
			if (x.sb_v >= x.sb_r + bit32) begin
				y.sb_v = x.sb_v - (x.sb_r + bit32);
				y.sb_r = (x.sb_r >> 1) + bit32;
			end else begin
				y.sb_r = x.sb_r >> 1;
			end
		end
		if (k >= SQ_FIRST && k <= DA_LAST) begin
			qrem = {x.ra[32:0], 1'b0};
			if (qrem >= 34'(x.dena)) begin
				y.ra = qrem - 34'(x.dena);
				y.qa = {x.qa[13:0], 1'b1};
			end else begin
				y.ra = qrem;
				y.qa = {x.qa[13:0], 1'b0};
			end
		end
		if (k >= SQ_FIRST && k <= DB_LAST) begin
			qrem = {x.rb[32:0], x.numb[DB_LAST - k]};
			if (qrem >= 34'(x.denb)) begin
				y.rb = qrem - 34'(x.denb);
				y.qb = {x.qb[21:0], 1'b1};
			end else begin
				y.rb = qrem;
				y.qb = {x.qb[21:0], 1'b0};
			end
		end
		if (k >= TD_FIRST && k <= TD_LAST) begin
			dvd = {x.sb_r[14:0], 16'd0};
			trem = {x.td_rem[15:0], dvd[TD_LAST - k]};
			if (trem >= 17'(x.den)) begin
				y.td_rem = trem - 17'(x.den);
				y.tq = {x.tq[29:0], 1'b1};
			end else begin
				y.td_rem = trem;
				y.tq = {x.tq[29:0], 1'b0};
			end
		end
		if (k == 37) begin
			y.prod = 62'(x.sq1_r[30:0]) * 62'(x.sq2_r[30:0]);
			y.mrem = {x.d[35:0], 28'd0};
		end
		if (k == 38) begin
			y.sat = x.mrem >= 64'(x.prod);
			y.mq = '0;
		end
		if (k >= MC_FIRST && k <= MC_LAST) begin
			mr = {x.mrem[62:0], 1'b0};
			if (mr >= 64'(x.prod)) begin
				y.mrem = mr - 64'(x.prod);
				y.mq = {x.mq[14:0], 1'b1};
			end else begin
				y.mrem = mr;
				y.mq = {x.mq[14:0], 1'b0};
			end
		end
		if (k == 55) begin
			if (!x.mc_ok) y.maxcos = '0;
			else if (x.sat) y.maxcos = 17'h10000;
			else y.maxcos = {1'b0, x.mq};
			y.tanv = x.cb_neg ? 32'(-$signed({1'b0, x.tq})) : {1'b0, x.tq};
			y.a = x.use_s ? (17'h10000 - 17'(x.qa)) : cfg_a;
			y.b = x.use_s ? 17'(x.qb[22:8]) : cfg_b;
		end
		if (k == 56) begin
			y.t1 = 18'((34'(x.b) * 34'(x.maxcos)) >> 16);
		end
		if (k == 57) begin
			sinq = {x.sn_r[14:0], 2'b00};
			t2w = 35'(x.t1) * 35'(sinq);
			y.t2 = 18'(t2w >> 16);
		end
		if (k == 58) begin
			t3w = $signed({1'b0, x.t2}) * $signed(x.tanv);
			y.t3 = 34'(t3w >>> 16);
		end
		if (k == 59) begin
			rs = $signed({18'd0, x.a}) + $signed(x.t3);
			if (rs < 0) y.refl = '0;
			else if (rs > $signed(35'h10000)) y.refl = 17'h10000;
			else y.refl = rs[16:0];
		end
		return y;
	endfunction

endpackage
`default_nettype wire

// File: hdl/oren_nayar_reflectance.sv
// Oren-Nayar diffuse reflectance pipeline, top level.
//
// Takes one beat per clock while s_tready is high: light, view and normal
// vectors in Q1.14 plus an optional per-sample roughness, and returns one
// Q1.16 reflectance beat per input beat, in order. The datapath is a 60-stage
// pipeline, and the sustained rate is one beat per cycle while the sink takes
// every result. Depth is set by the bit-serial units
// laid out one step per stage: two 31-step square roots for the projection
// lengths followed by the 16-step cosine quotient, with the sine root, tangent
// divider and roughness dividers running beside them. The whole pipeline
// advances together; a one-entry skid register after the last stage holds a
// result the sink does not take, so s_tready drops only while that register
// is full. coeff_a and coeff_b are written through the cfg port (always
// ready) and must only change while no beat is in flight.
`default_nettype none
module oren_nayar_reflectance (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// light_x, light_y, light_z, view_x, view_y, view_z,
	// normal_x, normal_y, normal_z, sample_sigma (16 bits each)
	input  wire logic [159:0] s_tdata,
	// use_sample_sigma
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// reflectance [16:0], zero padding [23:17]
	output logic [23:0]       m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_index,
	input  wire logic [16:0]  cfg_data
);
	import onr_pkg::*;

	logic [16:0] coeff_a_q;
	logic [16:0] coeff_b_q;
	item_t       in_item;
	item_t       pipe_s [1:NSTAGE];
	logic        vld_s [1:NSTAGE];
	logic        adv;
	logic        skid_full_q;
	logic [16:0] skid_q;

	// Registers take every beat on the cfg channel.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_a_q <= 17'h10000;
			coeff_b_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COEFF_A: coeff_a_q <= cfg_data;
				REG_COEFF_B: coeff_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the whole pipeline unless the skid register holds a result.
	assign adv = !skid_full_q;
	assign s_tready = adv;

	// Unpack the input beat into the item fed to the first stage.
	always_comb begin
		in_item = '0;
		for (int j = 0; j < 3; j++) begin
			in_item.lv[j] = s_tdata[16*j +: 16];
			in_item.vv[j] = s_tdata[48 + 16*j +: 16];
			in_item.nv[j] = s_tdata[96 + 16*j +: 16];
		end
		in_item.sigma = s_tdata[159:144];
		in_item.use_s = s_tuser;
	end

	// Stage k applies its slice of the math to the item entering it.
	for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
		item_t stage_in;
		logic  vld_in;

		// The first stage takes the input beat, later ones the previous register.
		if (k == 0) begin : g_head
			assign stage_in = in_item;
			assign vld_in = s_tvalid;
		end else begin : g_body
			assign stage_in = pipe_s[k];
			assign vld_in = vld_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_s[k+1] <= stage_step(stage_in, k, coeff_a_q, coeff_b_q);
			end
		end
	end

	// Catch the last-stage result when the sink stalls; release when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (m_tready) skid_full_q <= 1'b0;
		end else if (vld_s[NSTAGE] && !m_tready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && vld_s[NSTAGE] && !m_tready) begin
			skid_q <= pipe_s[NSTAGE].refl;
		end
	end

	assign m_tvalid = skid_full_q || vld_s[NSTAGE];
	assign m_tdata = {7'd0, skid_full_q ? skid_q : pipe_s[NSTAGE].refl};

endmodule
`default_nettype wire

// File: hdl/onr_checker.sv
// Port-level checks of the reflectance pipeline and their binding.
`default_nettype none
module onr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	// Hold a stalled output beat.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output beat changed while stalled");

	// Input back-pressure only comes from a waiting result.
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// Result is clamped to one in Q1.16 with zero padding.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:17] == 7'd0) &&
			((m_tdata[16] == 1'b0) || (m_tdata[15:0] == 16'd0)))
		else $error("reflectance out of range");

endmodule

bind oren_nayar_reflectance onr_checker u_onr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
`default_nettype wire

// File: tb/sv/oren_nayar_reflectance_tb.sv
// Self-checking testbench for the Oren-Nayar reflectance pipeline.
`default_nettype none
module oren_nayar_reflectance_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import onr_pkg::*;

	// One shading sample as it travels on the input bus.
	typedef struct {
		logic [2:0][15:0] lv;
		logic [2:0][15:0] vv;
		logic [2:0][15:0] nv;
		logic             use_s;
		logic [15:0]      sigma;
	} sample_t;

	localparam longint unsigned TAN_SAT = 64'hFFFFFFFF;
	localparam int LATENCY = NSTAGE + 4;
	localparam longint LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [159:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_index;
	logic [16:0] cfg_data;

	oren_nayar_reflectance uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor copy of the coefficient registers.
	logic [16:0] coef_a;
	logic [16:0] coef_b;

	sample_t pending_samples[$];
	logic [16:0] expected_refl[$];
	int errors;
	longint cycle_count;
	bit src_idle_on;
	bit sink_idle_on;
	bit sink_hold;
	bit src_pause;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_shr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clamp_unit(input longint v);
		if (v > longint'(ONE)) return longint'(ONE);
		if (v < -longint'(ONE)) return -longint'(ONE);
		return v;
	endfunction

	// Work out the reflectance of one sample.
	function automatic logic [16:0] predict_reflectance(input sample_t s);
		longint l[3], v[3], n[3], p1[3], p2[3];
		longint one, th, dl, dv, ci, co, ca, cb, tanv, t, r, d, n1, n2;
		longint unsigned mc, sinq, sb, den, q, a, b, s1, s2, prod, rem, sg, sg2;
		one = longint'(ONE);
		th = longint'(TH);
		dl = 0; dv = 0; mc = 0; d = 0; n1 = 0; n2 = 0;
		for (int k = 0; k < 3; k++) begin
			l[k] = $signed(s.lv[k]);
			v[k] = $signed(s.vv[k]);
			n[k] = $signed(s.nv[k]);
			dl += n[k] * l[k];
			dv += n[k] * v[k];
		end
		ci = clamp_unit(floor_shr(dl, FRAC));
		co = clamp_unit(floor_shr(dv, FRAC));
		if (ci < th && co < th) begin
			for (int k = 0; k < 3; k++) begin
				p1[k] = floor_shr(l[k] * one - n[k] * ci, FRAC);
				p2[k] = floor_shr(v[k] * one - n[k] * co, FRAC);
				d += p1[k] * p2[k];
				n1 += p1[k] * p1[k];
				n2 += p2[k] * p2[k];
			end
			if (d > 0 && n1 > 0 && n2 > 0) begin
				s1 = int_sqrt(longint'(n1) << 28);
				s2 = int_sqrt(longint'(n2) << 28);
				prod = s1 * s2;
				rem = longint'(d) << 28;
				if (rem >= prod) mc = 65536;
				else for (int k = 0; k < 16; k++) begin
					rem <<= 1;
					mc <<= 1;
					if (rem >= prod) begin
						rem -= prod;
						mc |= 1;
					end
				end
			end
		end
		if (co >= ci) begin
			ca = ci; cb = co;
		end else begin
			ca = co; cb = ci;
		end
		sinq = int_sqrt(one * one - ca * ca) << (16 - FRAC);
		sb = int_sqrt(one * one - cb * cb);
		den = (cb == 0) ? 1 : (cb < 0 ? -cb : cb);
		q = (sb << 16) / den;
		if (q > TAN_SAT) q = TAN_SAT;
		tanv = (cb < 0) ? -longint'(q) : longint'(q);
		if (s.use_s) begin
			sg = s.sigma;
			sg2 = sg * sg;
			a = 65536 - ((sg2 << 15) / (sg2 + K33));
			b = ((sg2 * K45) / (sg2 + K09)) >> 8;
		end else begin
			a = coef_a;
			b = coef_b;
		end
		t = longint'((((b * mc) >> 16) * sinq) >> 16);
		t = floor_shr(t * tanv, 16);
		r = longint'(a) + t;
		if (r < 0) r = 0;
		if (r > 65536) r = 65536;
		return r[16:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [16:0] got,
			input logic [16:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
	endtask

	// Driver: present the oldest pending sample, advance on each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_refl.push_back(predict_reflectance(pending_samples[0]));
				void'(pending_samples.pop_front());
			end
			// decide the next beat from what remains after this handshake
			if (s_tvalid && !s_tready) begin
				// hold the current beat stable
			end else if (pending_samples.size() > 0
					&& !src_pause && !(src_idle_on && $urandom_range(99) < 15)) begin
				s_tvalid <= 1'b1;
				s_tdata <= {pending_samples[0].sigma, pending_samples[0].nv,
					pending_samples[0].vv, pending_samples[0].lv};
				s_tuser <= pending_samples[0].use_s;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: check each accepted result beat against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (m_tvalid && m_tready) begin
				if (expected_refl.size() == 0) begin
					report_mismatch("unexpected beat", m_tdata[16:0], 17'd0);
				end else begin
					if (m_tdata[16:0] !== expected_refl[0])
						report_mismatch("reflectance", m_tdata[16:0], expected_refl[0]);
					if (m_tdata[23:17] !== 7'd0)
						report_mismatch("padding", 17'(m_tdata[23:17]), 17'd0);
					void'(expected_refl.pop_front());
				end
			end
			m_tready <= !sink_hold && !(sink_idle_on && $urandom_range(99) < 15);
			if (cycle_count > LIMIT) begin
				$display("[oren_nayar_reflectance] ERROR");
				$finish;
			end
		end
	end

	function automatic logic [15:0] rnd_comp();
		return 16'($urandom_range(32768) - 16384);
	endfunction

	// A roughly unit vector, built from a random direction and normalized.
	function automatic logic [2:0][15:0] rnd_unit();
		longint c[3];
		longint m;
		logic [2:0][15:0] u;
		do begin
			m = 0;
			for (int k = 0; k < 3; k++) begin
				c[k] = longint'($urandom_range(2000)) - 1000;
				m += c[k] * c[k];
			end
		end while (m < 100);
		m = int_sqrt(m);
		for (int k = 0; k < 3; k++) u[k] = 16'((c[k] * 16384) / m);
		return u;
	endfunction

	function automatic sample_t rnd_sample();
		sample_t s;
		int mode;
		mode = int'($urandom_range(9));
		if (mode < 7) begin
			s.lv = rnd_unit();
			s.vv = rnd_unit();
			s.nv = rnd_unit();
			// flip toward the normal so most samples see both vectors lit
			if ($urandom_range(3) != 0) begin
				for (int k = 0; k < 3; k++) begin
					s.lv[k] = 16'($signed(s.nv[k]) / 2 + $signed(s.lv[k]) / 2);
					s.vv[k] = 16'($signed(s.nv[k]) / 2 + $signed(s.vv[k]) / 2);
				end
			end
		end else if (mode < 9) begin
			for (int k = 0; k < 3; k++) begin
				s.lv[k] = rnd_comp();
				s.vv[k] = rnd_comp();
				s.nv[k] = rnd_comp();
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				s.lv[k] = 16'($urandom);
				s.vv[k] = 16'($urandom);
				s.nv[k] = 16'($urandom);
			end
		end
		s.use_s = 1'($urandom_range(1));
		s.sigma = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4096));
		return s;
	endfunction

	function automatic sample_t mk(input int lx, ly, lz, vx, vy, vz, nx, ny, nz,
			input bit us, input int sg);
		sample_t s;
		s.lv = {16'(lz), 16'(ly), 16'(lx)};
		s.vv = {16'(vz), 16'(vy), 16'(vx)};
		s.nv = {16'(nz), 16'(ny), 16'(nx)};
		s.use_s = us;
		s.sigma = 16'(sg);
		return s;
	endfunction

	task automatic wait_drained();
		while (pending_samples.size() != 0 || s_tvalid || expected_refl.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// Write one coefficient register while the pipeline is empty.
	task automatic write_coeff(input logic [7:0] idx, input logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_COEFF_A) coef_a = val;
		else if (idx == REG_COEFF_B) coef_b = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_random(input int count);
		for (int i = 0; i < count; i++) pending_samples.push_back(rnd_sample());
	endtask

	initial begin
		logic [16:0] a_set[5];
		logic [16:0] b_set[5];
		errors = 0;
		coef_a = 17'd65536;
		coef_b = 17'd0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		sink_hold = 1'b0;
		src_pause = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_coeff(REG_COEFF_B, 17'd30000);
		// Directed: normal incidence, grazing, negative cosines, zero cosine,
		// degenerate projection, off-sphere extremes, sigma extremes.
		pending_samples.push_back(mk(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 0, 0));
		pending_samples.push_back(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0));
		pending_samples.push_back(mk(11585, 0, 11585, 0, 11585, 11585, 0, 0, 16384, 0, 0));
		pending_samples.push_back(mk(11585, 0, 11585, -11585, 0, 11585, 0, 0, 16384, 0, 0));
		pending_samples.push_back(mk(11585, 0, -11585, 0, 11585, 11585, 0, 0, 16384, 0, 0));
		pending_samples.push_back(mk(0, 0, -16384, 0, 0, -16384, 0, 0, 16384, 0, 0));
		pending_samples.push_back(mk(16384, 0, 0, 16384, 0, 0, 0, 0, 16384, 0, 0));
		pending_samples.push_back(mk(16384, 16384, 16384, 16384, 16384, 16384,
			16384, 16384, 16384, 0, 0));
		pending_samples.push_back(mk(-16384, -16384, -16384, -16384, -16384, -16384,
			-16384, -16384, -16384, 1, 65535));
		pending_samples.push_back(mk(-32768, 32767, -32768, 32767, -32768, 32767,
			32767, -32768, 32767, 1, 65535));
		pending_samples.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_samples.push_back(mk(9000, 3000, 13000, -7000, 2000, 14000, 0, 0, 16384, 1, 0));
		pending_samples.push_back(mk(9000, 3000, 13000, -7000, 2000, 14000, 0, 0, 16384, 1,
			4096));
		pending_samples.push_back(mk(9000, 3000, 13000, 7000, 2000, 14000, 0, 0, 16384, 1,
			1229));
		pending_samples.push_back(mk(16383, 100, 100, 100, 16383, 100, 100, 100, 16383, 0, 0));
		pending_samples.push_back(mk(2, 0, 16383, 0, 1, 16383, 0, 0, 16384, 0, 0));
		wait_drained();

		// Sweep coefficient settings, extremes included, with random samples.
		a_set = '{17'd0, 17'd65536, 17'd131071, 17'd40000, 17'd65536};
		b_set = '{17'd65536, 17'd0, 17'd131071, 17'd20000, 17'd45000};
		for (int p = 0; p < 5; p++) begin
			write_coeff(REG_COEFF_A, a_set[p]);
			write_coeff(REG_COEFF_B, b_set[p]);
			write_coeff(8'd2 + 8'(p), 17'($urandom));
			src_idle_on = (p != 1);
			sink_idle_on = (p != 1);
			add_random(337);
			if (p == 2) begin
				// hold the sink off long enough to back up the whole pipeline
				while (pending_samples.size() > 200) @(posedge clk);
				sink_hold = 1'b1;
				repeat (200) @(posedge clk);
				sink_hold = 1'b0;
			end
			if (p == 3) begin
				// pause the source until every result is back, then resume
				while (pending_samples.size() > 150) @(posedge clk);
				src_pause = 1'b1;
				@(posedge clk);
				while (s_tvalid || expected_refl.size() != 0) @(posedge clk);
				src_pause = 1'b0;
			end
			wait_drained();
		end

		if (errors == 0) begin
			$display("[oren_nayar_reflectance] OK");
		end else begin
			$display("[oren_nayar_reflectance] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
